### rtl/core/cvl_pkg.sv
// ----------------------------------------------------------------------------
// CORDIC vector angle/length package
// Shared types and constants for the vectoring pipeline.
// ----------------------------------------------------------------------------
package cvl_pkg;

  localparam int unsigned NumSteps  = 7;
  localparam int unsigned AccWidth  = 10;
  localparam int unsigned DataWidth = 32;

  // Accumulator start values, in half-steps of 512 per turn.
  localparam logic [AccWidth-1:0] AccStartNeg = 10'h180;
  localparam logic [AccWidth-1:0] AccStartPos = 10'h080;

  // Gain correction multiplier; the length is the low product word >>> 20.
  localparam logic [DataWidth-1:0] GainMul   = 32'h0009_B74E;
  localparam int unsigned          GainShift = 20;

  localparam int unsigned DirWidth = 8;
  localparam int unsigned LenWidth = 12;

  // Rotation angle per step, in half-steps.
  localparam logic [6:0] StepAngle [NumSteps] = '{
    7'd64, 7'd37, 7'd19, 7'd10, 7'd5, 7'd2, 7'd1
  };

  typedef struct packed {
    logic signed [DataWidth-1:0] x;
    logic signed [DataWidth-1:0] y;
    logic [AccWidth-1:0]         acc;
  } cvl_data_t;

endpackage

### rtl/core/cvl_stage.sv
// ----------------------------------------------------------------------------
// CORDIC vectoring stage
// One registered micro-rotation with its own valid bit and back-pressure.
// ----------------------------------------------------------------------------
module cvl_stage #(
  parameter int unsigned Step = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cvl_pkg::cvl_data_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cvl_pkg::cvl_data_t out_data
);
  import cvl_pkg::*;

  cvl_data_t data_next;
  logic signed [DataWidth-1:0] sx;
  logic signed [DataWidth-1:0] sy;

  assign sx = in_data.x >>> Step;
  assign sy = in_data.y >>> Step;

  // Drive y toward zero: the sign of y picks the rotation direction.
  always_comb begin
    if (in_data.y[DataWidth-1]) begin
      data_next.y   = in_data.y + sx;
      data_next.x   = in_data.x - sy;
      data_next.acc = in_data.acc - {3'b000, StepAngle[Step]};
    end else begin
      data_next.y   = in_data.y - sx;
      data_next.x   = in_data.x + sy;
      data_next.acc = in_data.acc + {3'b000, StepAngle[Step]};
    end
  end

  // A stage takes new data when it is empty or its content moves on.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### rtl/core/cordic_vector_angle_length.sv
// ----------------------------------------------------------------------------
// CORDIC vector angle and length
// Pipeline: 1 fold stage, 7 rotation stages and 1 gain multiply stage that is
// also the output register. Throughput: one vector per cycle while m_tready is
// high; each stage has its own valid bit, so bubbles collapse under
// back-pressure. Reset clears all valid bits.
// ----------------------------------------------------------------------------
module cordic_vector_angle_length (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // vec_x [31:0], vec_y [63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // direction [7:0], length [19:8], zero [23:20]
);
  import cvl_pkg::*;

  logic signed [DataWidth-1:0] vec_x;
  logic signed [DataWidth-1:0] vec_y;

  assign vec_x = s_tdata[31:0];
  assign vec_y = s_tdata[63:32];

  // Stage chain signals: index 0 is the fold stage, NumSteps is the last rotation.
  logic      st_valid [NumSteps+1];
  logic      st_ready [NumSteps+1];
  cvl_data_t st_data  [NumSteps+1];

  // Fold stage: move the vector into the right half-plane.
  cvl_data_t fold_next;

  always_comb begin
    if (vec_x[DataWidth-1]) begin
      fold_next.x   = -vec_x;
      fold_next.y   = -vec_y;
      fold_next.acc = AccStartNeg;
    end else begin
      fold_next.x   = vec_x;
      fold_next.y   = vec_y;
      fold_next.acc = AccStartPos;
    end
  end

  assign s_tready = !st_valid[0] || st_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (s_tready) begin
      st_valid[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      st_data[0] <= fold_next;
    end
  end

  for (genvar g = 0; g < NumSteps; g++) begin : g_rot
    cvl_stage #(
      .Step(g)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (st_valid[g]),
      .in_ready (st_ready[g]),
      .in_data  (st_data[g]),
      .out_valid(st_valid[g+1]),
      .out_ready(st_ready[g+1]),
      .out_data (st_data[g+1])
    );
  end

  // Gain stage: multiply by the CORDIC gain correction, keep the low word.
  logic [DataWidth-1:0] x_word;
  logic [DataWidth-1:0] prod_next;
  logic [DataWidth-1:0] prod;
  logic [DirWidth-1:0]  direction;

  assign x_word    = st_data[NumSteps].x;
  assign prod_next = x_word * GainMul;

  assign st_ready[NumSteps] = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (st_ready[NumSteps]) begin
      m_tvalid <= st_valid[NumSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (st_ready[NumSteps] && st_valid[NumSteps]) begin
      prod      <= prod_next;
      direction <= st_data[NumSteps].acc[DirWidth:1];
    end
  end

  // The arithmetic shift by GainShift keeps only the top bits of the low word.
  assign m_tdata = {4'b0000, prod[DataWidth-1:GainShift], direction};

  // An empty output register lets the whole chain advance.
  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty output register");

  a_accept_fills_fold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> st_valid[0])
    else $error("accepted vector not held in fold stage");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

### tb/sv/cordic_vector_angle_length_checker.sv
// ----------------------------------------------------------------------------
// CORDIC vector angle/length checker
// Watches both stream channels, predicts direction and length for every
// accepted vector and compares each output transfer against the oldest one.
// ----------------------------------------------------------------------------
module cordic_vector_angle_length_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import cvl_pkg::*;

  typedef struct packed {
    logic [DirWidth-1:0] direction;
    logic [LenWidth-1:0] length;
  } polar_t;

  polar_t polar_expected[$];

  // Folds the vector into the right half plane, runs the seven vectoring
  // rotations and applies the gain correction to the final x.
  function automatic polar_t vector_polar(input logic [DataWidth-1:0] vx,
                                          input logic [DataWidth-1:0] vy);
    logic signed [DataWidth-1:0] px;
    logic signed [DataWidth-1:0] py;
    logic signed [DataWidth-1:0] sx;
    logic signed [DataWidth-1:0] sy;
    logic [AccWidth-1:0]         turn;
    logic [DataWidth-1:0]        gain_prod;
    polar_t                      res;
    if (vx[DataWidth-1]) begin
      px   = -vx;
      py   = -vy;
      turn = AccStartNeg;
    end else begin
      px   = vx;
      py   = vy;
      turn = AccStartPos;
    end
    for (int i = 0; i < NumSteps; i++) begin
      sx = px >>> i;
      sy = py >>> i;
      if (py[DataWidth-1]) begin
        py   = py + sx;
        px   = px - sy;
        turn = turn - AccWidth'(StepAngle[i]);
      end else begin
        py   = py - sx;
        px   = px + sy;
        turn = turn + AccWidth'(StepAngle[i]);
      end
    end
    gain_prod     = px * GainMul;
    res.direction = turn[DirWidth:1];
    res.length    = gain_prod[DataWidth-1 -: LenWidth];
    return res;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    polar_t exp_polar;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (polar_expected.size() == 0) begin
          $error("output transfer with nothing expected: tdata=%h", m_tdata);
          fail_count++;
        end else begin
          exp_polar = polar_expected.pop_front();
          if (m_tdata[7:0] !== exp_polar.direction) begin
            $error("direction: expected %h, got %h", exp_polar.direction, m_tdata[7:0]);
            fail_count++;
          end
          if (m_tdata[19:8] !== exp_polar.length) begin
            $error("length: expected %h, got %h", exp_polar.length, m_tdata[19:8]);
            fail_count++;
          end
          if (m_tdata[23:20] !== 4'h0) begin
            $error("pad: expected %h, got %h", 4'h0, m_tdata[23:20]);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        polar_expected.push_back(vector_polar(s_tdata[31:0], s_tdata[63:32]));
      end
      pending = polar_expected.size();
    end
  end

endmodule

### tb/sv/cordic_vector_angle_length_tb.sv
// ----------------------------------------------------------------------------
// CORDIC vector angle/length testbench
// Sends directed corner vectors and then random ones under three idling
// patterns; the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module cordic_vector_angle_length_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomPerPhase = 150;
  localparam int CycleLimit     = 200000;
  localparam int DrainCycles    = 20;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // vec_x [31:0], vec_y [63:32]
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // direction [7:0], length [19:8], zero [23:20]

  int fail_count;
  int pending;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;

  cordic_vector_angle_length dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  cordic_vector_angle_length_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_vector(input logic [31:0] vx, input logic [31:0] vy);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {vy, vx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_component();
    logic [31:0] v;
    case ($urandom_range(4))
      0, 1: v = $urandom;
      2: v = 32'($signed($urandom_range(8191)) - 4096);
      3: v = 32'($signed($urandom_range(32'h01FF_FFFF)) - 32'sh0100_0000);
      default: begin
        case ($urandom_range(4))
          0: v = 32'h0000_0000;
          1: v = 32'h0000_0001;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h8000_0000;
          default: v = 32'h7FFF_FFFF;
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin
    cycle_count   = 0;
    send_idle_pct = 8;
    recv_idle_pct = 59;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Zero, the four axes, the diagonals of each quadrant and full-scale
    // corners, including the most negative x, which does not survive negation.
    send_vector(32'h0000_0000, 32'h0000_0000);
    send_vector(32'd1000, 32'd0);
    send_vector(32'd0, 32'd1000);
    send_vector(-32'sd1000, 32'd0);
    send_vector(32'd0, -32'sd1000);
    send_vector(32'd1000, 32'd1000);
    send_vector(-32'sd1000, 32'd1000);
    send_vector(-32'sd1000, -32'sd1000);
    send_vector(32'd1000, -32'sd1000);
    send_vector(32'd1, -32'sd100000);
    send_vector(32'h7FFF_FFFF, 32'h0000_0000);
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vector(32'h7FFF_FFFF, 32'h8000_0000);
    send_vector(32'h8000_0000, 32'h0000_0000);
    send_vector(32'h8000_0000, 32'h8000_0000);
    send_vector(32'h8000_0000, 32'h7FFF_FFFF);
    send_vector(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_vector(32'h0000_0001, 32'h0000_0001);
    send_vector(32'h0004_0000, 32'h0003_0000);
    send_vector(32'h4000_0000, 32'hC000_0000);
    send_vector(32'hAAAA_AAAA, 32'h5555_5555);
    send_vector(32'h5555_5555, 32'hAAAA_AAAA);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 8;  recv_idle_pct = 59; end
        1: begin send_idle_pct = 59; recv_idle_pct = 8;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < RandomPerPhase; n++) begin
        send_vector(pick_component(), pick_component());
      end
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
